### rtl/core/bb3_pkg.sv
package bb3_pkg;

  // register indexes on the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
  localparam logic [11:0] IMAGE_HEIGHT_RESET = 12'd480;
  localparam logic [11:0] GEOM_MIN           = 12'd3;

  // sum / 9 == (sum * 7282) >> 16 for every sum of nine bytes
  localparam logic [12:0] RECIP_NINE  = 13'd7282;
  localparam int unsigned RECIP_SHIFT = 16;

  // channel codes, one lane each
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;
  localparam int unsigned NUM_CH  = 3;

  typedef struct packed {
    logic       start_of_frame;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic        last_in_run;
  } out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // one window column: rows r-2, r-1, r
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } wcol_t;

  // one line store entry: rows r-2 and r-1 at a column
  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_pair_t;

  // pixel in flight with its output tags
  typedef struct packed {
    logic        blur;
    logic        border;
    logic [11:0] row;
    logic [10:0] col;
    pixel_t      px;
  } job_t;

  typedef struct packed {
    logic sum_en;
    logic quo_en;
  } lane_ctl_t;

  function automatic logic [7:0] chan_of(pixel_t p, logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      CH_BLUE:  v = p.blue;
      CH_GREEN: v = p.green;
      CH_RED:   v = p.red;
      default:  v = p.blue;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/bb3_linebuf.sv
module bb3_linebuf #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  bb3_pkg::line_pair_t wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output bb3_pkg::line_pair_t rdata_o
);

  bb3_pkg::line_pair_t mem_q [Depth];
  bb3_pkg::line_pair_t rd_q;

  // write-first: a read of the address written in the same cycle sees new data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rd_q <= wdata_i;
      end else begin
        rd_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_q;

endmodule

### rtl/core/bb3_lane.sv
module bb3_lane (
  input  logic               clk_i,
  input  bb3_pkg::lane_ctl_t ctl_i,
  input  logic [8:0][7:0]    taps_i,
  output logic [7:0]         quo_o
);

  logic [11:0] sum_d;
  logic [11:0] sum_q;
  logic [24:0] prod;
  logic [7:0]  quo_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 9; i++) begin
      sum_d = sum_d + 12'(taps_i[i]);
    end
  end

  assign prod = 25'(sum_q) * 25'(bb3_pkg::RECIP_NINE);

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_q <= sum_d;
    end
    if (ctl_i.quo_en) begin
      quo_q <= prod[bb3_pkg::RECIP_SHIFT +: 8];
    end
  end

  assign quo_o = quo_q;

endmodule

### rtl/core/bb3_merge.sv
module bb3_merge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  bb3_pkg::job_t   job_i,
  input  bb3_pkg::pixel_t blur_px_i,
  output logic            job_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bb3_pkg::out_t   out_data_o
);

  bb3_pkg::job_t job_q;
  logic          pend_blur_q;
  logic          pend_border_q;
  logic          last_beat;

  assign out_valid_o = pend_blur_q | pend_border_q;
  assign last_beat   = ~(pend_blur_q & pend_border_q);
  assign job_ready_o = ~out_valid_o | (out_ready_i & last_beat);

  // blurred neighbour first, then the pass-through border pixel
  always_comb begin
    out_data_o.last_in_run = last_beat;
    if (pend_blur_q) begin
      out_data_o.out_row   = job_q.row - 12'd1;
      out_data_o.out_col   = job_q.col - 11'd1;
      out_data_o.out_blue  = blur_px_i.blue;
      out_data_o.out_green = blur_px_i.green;
      out_data_o.out_red   = blur_px_i.red;
    end else begin
      out_data_o.out_row   = job_q.row;
      out_data_o.out_col   = job_q.col;
      out_data_o.out_blue  = job_q.px.blue;
      out_data_o.out_green = job_q.px.green;
      out_data_o.out_red   = job_q.px.red;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_blur_q   <= 1'b0;
      pend_border_q <= 1'b0;
    end else if (load_i) begin
      pend_blur_q   <= job_i.blur;
      pend_border_q <= job_i.border;
    end else if (out_valid_o && out_ready_i) begin
      if (pend_blur_q) begin
        pend_blur_q <= 1'b0;
      end else begin
        pend_border_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

endmodule

### rtl/core/box_blur_3x3_rgb.sv
// channel | direction | handshake              | beat
// --------+-----------+------------------------+-----------------------------------
// in      | input     | in_valid_i / in_ready_o | one rgb pixel, raster order, sof flag
// out     | output    | out_valid_o / out_ready_i | one tagged pixel, blurred or border
// cfg     | input     | cfg_we_i (no wait)     | image_width or image_height write
//
// one pixel beat per cycle sustained while the output is ready; a pixel that causes two
// results holds the input while the output sequencer sends its second beat
// a pixel's first result beat becomes visible after these registers load in order: the line
// store read on the pixel beat itself, then the channel sums, then the reciprocal multiply
// reset clears counters, valid bits and sequencer and loads the geometry defaults; line stores
// and window are not cleared, an entry is written before any blurred result uses it
// a stall at the output backs up through the stages; empty stages still fill
module box_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bb3_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bb3_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [11:0]    cfg_wdata_i
);

  localparam int unsigned ColW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);

  // configuration
  logic [11:0] width_q;
  logic [11:0] height_q;
  logic [WW-1:0] w_eff;
  logic [11:0]   h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3_pkg::IMAGE_WIDTH_RESET;
      height_q <= bb3_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bb3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        bb3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // width clamps to 3..MAX_WIDTH, height to at least 3
  always_comb begin
    if (width_q < bb3_pkg::GEOM_MIN) begin
      w_eff = WW'(bb3_pkg::GEOM_MIN);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q < bb3_pkg::GEOM_MIN) ? bb3_pkg::GEOM_MIN : height_q;
  end

  // position of the arriving pixel
  logic [ColW-1:0] col_q;
  logic [11:0]     row_q;
  logic [ColW-1:0] c_pre;
  logic [11:0]     r_pre;
  logic [12:0]     r_step;
  logic [ColW-1:0] c_cur;
  logic [11:0]     r_cur;
  logic [WW-1:0]   col_n;
  logic            last_col;
  logic [12:0]     row_n;
  logic            accept;

  always_comb begin
    c_pre = in_data_i.start_of_frame ? '0 : col_q;
    r_pre = in_data_i.start_of_frame ? '0 : row_q;
    // geometry may have shrunk under the counters
    if (WW'(c_pre) >= w_eff) begin
      c_cur  = '0;
      r_step = 13'(r_pre) + 13'd1;
    end else begin
      c_cur  = c_pre;
      r_step = 13'(r_pre);
    end
    r_cur    = (r_step >= 13'(h_eff)) ? 12'd0 : r_step[11:0];
    col_n    = WW'(c_cur) + WW'(1);
    last_col = (col_n >= w_eff);
    row_n    = 13'(r_cur) + 13'd1;
  end

  assign accept = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= (row_n >= 13'(h_eff)) ? 12'd0 : row_n[11:0];
      end else begin
        col_q <= col_n[ColW-1:0];
        row_q <= r_cur;
      end
    end
  end

  bb3_pkg::job_t job0;
  always_comb begin
    job0.blur     = (r_cur >= 12'd2) && (c_cur >= ColW'(2));
    job0.border   = (r_cur == 12'd0) || (r_cur == h_eff - 12'd1) ||
                    (c_cur == '0) || last_col;
    job0.row      = r_cur;
    job0.col      = 11'(c_cur);
    job0.px.red   = in_data_i.in_red;
    job0.px.green = in_data_i.in_green;
    job0.px.blue  = in_data_i.in_blue;
  end

  // stage handshake: a stage takes a beat when empty or when its beat moves on
  logic            v1_q;
  logic            v2_q;
  logic            adv1;
  logic            adv2;
  logic            adv3;
  logic            s1_move;
  logic            s2_move;
  bb3_pkg::job_t   job1_q;
  bb3_pkg::job_t   job2_q;
  logic [ColW-1:0] addr1_q;

  assign adv2       = ~v2_q | adv3;
  assign adv1       = ~v1_q | adv2;
  assign in_ready_o = adv1;
  assign s1_move    = v1_q & adv2;
  assign s2_move    = v2_q & adv3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job1_q  <= job0;
      addr1_q <= c_cur;
    end
    if (s1_move) begin
      job2_q <= job1_q;
    end
  end

  // line stores: rows r-2 and r-1 share one entry per column
  bb3_pkg::line_pair_t rd_pair;
  bb3_pkg::line_pair_t wr_pair;

  assign wr_pair.older = rd_pair.newer;
  assign wr_pair.newer = job1_q.px;

  bb3_linebuf #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW)
  ) u_linebuf (
    .clk_i   (clk_i),
    .we_i    (s1_move),
    .waddr_i (addr1_q),
    .wdata_i (wr_pair),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (rd_pair)
  );

  // 3x3 window: current column plus the two before it
  bb3_pkg::wcol_t col3;
  bb3_pkg::wcol_t win0_q;
  bb3_pkg::wcol_t win1_q;

  assign col3.top = rd_pair.older;
  assign col3.mid = rd_pair.newer;
  assign col3.bot = job1_q.px;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      win1_q <= win0_q;
      win0_q <= col3;
    end
  end

  // one lane per colour channel
  bb3_pkg::lane_ctl_t lane_ctl;
  logic [7:0]         quo [bb3_pkg::NUM_CH];
  bb3_pkg::pixel_t    blur_px;

  assign lane_ctl.sum_en = s1_move;
  assign lane_ctl.quo_en = s2_move;

  for (genvar ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin : g_lane
    logic [8:0][7:0] taps;
    assign taps = {
      bb3_pkg::chan_of(col3.top, 2'(ch)),   bb3_pkg::chan_of(col3.mid, 2'(ch)),
      bb3_pkg::chan_of(col3.bot, 2'(ch)),   bb3_pkg::chan_of(win0_q.top, 2'(ch)),
      bb3_pkg::chan_of(win0_q.mid, 2'(ch)), bb3_pkg::chan_of(win0_q.bot, 2'(ch)),
      bb3_pkg::chan_of(win1_q.top, 2'(ch)), bb3_pkg::chan_of(win1_q.mid, 2'(ch)),
      bb3_pkg::chan_of(win1_q.bot, 2'(ch))
    };
    bb3_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .taps_i (taps),
      .quo_o  (quo[ch])
    );
  end

  assign blur_px.blue  = quo[bb3_pkg::CH_BLUE];
  assign blur_px.green = quo[bb3_pkg::CH_GREEN];
  assign blur_px.red   = quo[bb3_pkg::CH_RED];

  // merging stage: joins the lanes and sends zero, one or two beats per pixel
  bb3_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s2_move),
    .job_i       (job2_q),
    .blur_px_i   (blur_px),
    .job_ready_o (adv3),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
